// File: rtl/wrmf_pkg.sv
package wrmf_pkg;

  localparam int PIXEL_W    = 16;
  localparam int MAX_HEIGHT = 4096;
  localparam int ROW_W      = 12;
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int WS_W       = 5;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_WINDOW = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = 2'd2;

  typedef struct packed {
    logic load;
    logic h_step;
    logic line_wr;
    logic v_read;
    logic v_step;
    logic emit;
  } wrmf_cmd_t;

  typedef struct packed {
    logic hvalid;
    logic wvalid;
    logic k_last;
    logic out_free;
  } wrmf_stat_t;

endpackage

// File: rtl/wrmf_ram.sv
module wrmf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

// File: rtl/wrmf_ctrl.sv
module wrmf_ctrl
  import wrmf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  wrmf_stat_t stat_i,
  output wrmf_cmd_t  cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_HSCAN = 3'd1;
  localparam logic [2:0] ST_WRITE = 3'd2;
  localparam logic [2:0] ST_VREAD = 3'd3;
  localparam logic [2:0] ST_VCMP  = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_HSCAN;
        end
      end
      ST_HSCAN: begin
        if (!stat_i.hvalid) begin
          state_d = ST_WRITE;
        end else begin
          cmd_o.h_step = 1'b1;
          if (stat_i.k_last) state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd_o.line_wr = 1'b1;
        state_d       = stat_i.wvalid ? ST_VREAD : ST_EMIT;
      end
      ST_VREAD: begin
        cmd_o.v_read = 1'b1;
        state_d      = ST_VCMP;
      end
      ST_VCMP: begin
        cmd_o.v_step = 1'b1;
        state_d      = stat_i.k_last ? ST_EMIT : ST_VREAD;
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

// File: rtl/wrmf_dp.sv
module wrmf_dp
  import wrmf_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [PIXEL_W-1:0]    pixel_i,
  input  logic                  start_of_frame_i,
  input  wrmf_cmd_t             cmd_i,
  output wrmf_stat_t            stat_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  window_valid_o,
  output logic [PIXEL_W-1:0]    window_max_o,
  output logic [PIXEL_W-1:0]    window_min_o,
  output logic [PIXEL_W-1:0]    best_range_o,
  output logic                  frame_done_o
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int CW1 = $clog2(MAX_WIDTH + 1);
  localparam int SW  = $clog2(MAX_WINDOW);
  localparam int WSW = $clog2(MAX_WINDOW + 1);
  localparam int DEPTH = MAX_WINDOW * MAX_WIDTH;
  localparam int AW  = $clog2(DEPTH);

  logic [FW_W-1:0] fw_q;
  logic [FH_W-1:0] fh_q;
  logic [WS_W-1:0] ws_q;
  logic [CW1-1:0]  w_eff;
  logic [FH_W-1:0] h_eff;
  logic [WSW-1:0]  ws_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= FW_W'(1024);
      fh_q <= FH_W'(1024);
      ws_q <= WS_W'(2);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_FRAME_WIDTH:  fw_q <= cfg_data_i[FW_W-1:0];
        CFG_FRAME_HEIGHT: fh_q <= cfg_data_i[FH_W-1:0];
        CFG_WINDOW_SIZE:  ws_q <= cfg_data_i[WS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (fw_q == '0) w_eff = CW1'(1);
    else if (32'(fw_q) > 32'(MAX_WIDTH)) w_eff = CW1'(MAX_WIDTH);
    else w_eff = CW1'(fw_q);
    if (fh_q == '0) h_eff = FH_W'(1);
    else if (32'(fh_q) > 32'(MAX_HEIGHT)) h_eff = FH_W'(MAX_HEIGHT);
    else h_eff = fh_q;
    if (ws_q == '0) ws_eff = WSW'(1);
    else if (32'(ws_q) > 32'(MAX_WINDOW)) ws_eff = WSW'(MAX_WINDOW);
    else ws_eff = WSW'(ws_q);
  end

  // position counters
  logic [CW-1:0]    col_q, col_cur;
  logic [ROW_W-1:0] row_q, row_cur;
  logic [SW-1:0]    slot_q, slot_cur, lslot_q, lslot_cur;
  logic             last_col, done_cur, hvalid_cur, wvalid_cur;
  logic [SW-1:0]    slot_inc, lslot_inc;

  assign col_cur   = start_of_frame_i ? '0 : col_q;
  assign row_cur   = start_of_frame_i ? '0 : row_q;
  assign slot_cur  = start_of_frame_i ? '0 : slot_q;
  assign lslot_cur = start_of_frame_i ? '0 : lslot_q;

  assign last_col   = (32'(col_cur) + 32'd1) >= 32'(w_eff);
  assign done_cur   = last_col && ((32'(row_cur) + 32'd1) >= 32'(h_eff));
  assign hvalid_cur = (32'(col_cur) + 32'd1) >= 32'(ws_eff);
  assign wvalid_cur = hvalid_cur && ((32'(row_cur) + 32'd1) >= 32'(ws_eff));
  assign slot_inc   = ((32'(slot_cur) + 32'd1) >= 32'(ws_eff)) ? '0 : slot_cur + 1'b1;
  assign lslot_inc  = ((32'(lslot_cur) + 32'd1) >= 32'(ws_eff)) ? '0 : lslot_cur + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      slot_q  <= '0;
      lslot_q <= '0;
    end else if (cmd_i.load) begin
      if (last_col) begin
        col_q  <= '0;
        slot_q <= '0;
        row_q   <= done_cur ? '0 : row_cur + 1'b1;
        lslot_q <= done_cur ? '0 : lslot_inc;
      end else begin
        col_q   <= col_cur + 1'b1;
        slot_q  <= slot_inc;
        row_q   <= row_cur;
        lslot_q <= lslot_cur;
      end
    end
  end

  // last pixels of the row
  logic [PIXEL_W-1:0] rpw_q [MAX_WINDOW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_WINDOW; i++) rpw_q[i] <= '0;
    end else if (cmd_i.load) begin
      rpw_q[slot_cur] <= pixel_i;
    end
  end

  // per beat working registers
  logic [CW-1:0]      col_r;
  logic [SW-1:0]      lslot_r, k_q;
  logic               hvalid_r, wvalid_r, done_r;
  logic [PIXEL_W-1:0] hmax_q, hmin_q, vmax_q, vmin_q, best_q;
  logic [AW-1:0]      rd_addr_q, wr_addr;
  logic [PIXEL_W-1:0] rd_max, rd_min, hv, range_v, best_new;
  logic               k_last;

  assign k_last  = (32'(k_q) + 32'd1) >= 32'(ws_eff);
  assign hv      = rpw_q[k_q];
  assign wr_addr = AW'(lslot_r) * AW'(MAX_WIDTH) + AW'(col_r);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      col_r    <= col_cur;
      lslot_r  <= lslot_cur;
      hvalid_r <= hvalid_cur;
      wvalid_r <= wvalid_cur;
      done_r   <= done_cur;
      hmax_q   <= pixel_i;
      hmin_q   <= pixel_i;
      k_q      <= '0;
    end
    if (cmd_i.h_step) begin
      if (hv > hmax_q) hmax_q <= hv;
      if (hv < hmin_q) hmin_q <= hv;
      k_q <= k_last ? '0 : k_q + 1'b1;
    end
    if (cmd_i.line_wr) begin
      vmax_q    <= hmax_q;
      vmin_q    <= hmin_q;
      rd_addr_q <= AW'(col_r);
    end
    if (cmd_i.v_step) begin
      if (rd_max > vmax_q) vmax_q <= rd_max;
      if (rd_min < vmin_q) vmin_q <= rd_min;
      rd_addr_q <= rd_addr_q + AW'(MAX_WIDTH);
      k_q       <= k_last ? '0 : k_q + 1'b1;
    end
  end

  wrmf_ram #(.WIDTH(PIXEL_W), .DEPTH(DEPTH)) u_max_lines (
    .clk_i     (clk_i),
    .wr_en_i   (cmd_i.line_wr),
    .wr_addr_i (wr_addr),
    .wr_data_i (hmax_q),
    .rd_en_i   (cmd_i.v_read),
    .rd_addr_i (rd_addr_q),
    .rd_data_o (rd_max)
  );

  wrmf_ram #(.WIDTH(PIXEL_W), .DEPTH(DEPTH)) u_min_lines (
    .clk_i     (clk_i),
    .wr_en_i   (cmd_i.line_wr),
    .wr_addr_i (wr_addr),
    .wr_data_i (hmin_q),
    .rd_en_i   (cmd_i.v_read),
    .rd_addr_i (rd_addr_q),
    .rd_data_o (rd_min)
  );

  assign range_v  = vmax_q - vmin_q;
  assign best_new = (wvalid_r && (range_v < best_q)) ? range_v : best_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q <= '1;
    end else if (cmd_i.load && start_of_frame_i) begin
      best_q <= '1;
    end else if (cmd_i.emit) begin
      best_q <= best_new;
    end
  end

  // output register
  logic               out_valid_q, wv_q, done_q;
  logic [PIXEL_W-1:0] omax_q, omin_q, obest_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      wv_q    <= wvalid_r;
      omax_q  <= wvalid_r ? vmax_q : '0;
      omin_q  <= wvalid_r ? vmin_q : '0;
      obest_q <= best_new;
      done_q  <= done_r;
    end
  end

  assign stat_o.hvalid   = hvalid_r;
  assign stat_o.wvalid   = wvalid_r;
  assign stat_o.k_last   = k_last;
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o    = out_valid_q;
  assign window_valid_o = wv_q;
  assign window_max_o   = omax_q;
  assign window_min_o   = omin_q;
  assign best_range_o   = obest_q;
  assign frame_done_o   = done_q;

endmodule

// File: rtl/window_range_min_finder.sv
// a pixel is accepted; once its row span is complete the row window is scanned, then the
//   line stores are written; with a full square they are read and compared row by row, and
//   the result is emitted when the output is free; no new pixel is taken before then
// reset: counters cleared, pixel row window zero, best range all ones, config at defaults
// line stores are not cleared; entries are written before any read of them
module window_range_min_finder
  import wrmf_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [PIXEL_W-1:0]    pixel_i,
  input  logic                  start_of_frame_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  window_valid_o,
  output logic [PIXEL_W-1:0]    window_max_o,
  output logic [PIXEL_W-1:0]    window_min_o,
  output logic [PIXEL_W-1:0]    best_range_o,
  output logic                  frame_done_o
);

  wrmf_cmd_t  cmd;
  wrmf_stat_t stat;

  wrmf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  wrmf_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_WINDOW(MAX_WINDOW)) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .pixel_i          (pixel_i),
    .start_of_frame_i (start_of_frame_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .window_valid_o   (window_valid_o),
    .window_max_o     (window_max_o),
    .window_min_o     (window_min_o),
    .best_range_o     (best_range_o),
    .frame_done_o     (frame_done_o)
  );

`ifndef SYNTHESIS
  a_max_ge_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && window_valid_o |-> window_max_o >= window_min_o)
    else $error("window max below min");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !window_valid_o |-> window_max_o == '0 && window_min_o == '0)
    else $error("nonzero extrema without full square");

  a_best_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && window_valid_o |-> best_range_o <= window_max_o - window_min_o)
    else $error("best range above current square range");
`endif

endmodule

// File: dv/window_range_min_finder_test.sv
`timescale 1ns / 100ps

module window_range_min_finder_test;
  import wrmf_pkg::*;

  localparam int LINE_W     = 1024;
  localparam int WIN_MAX    = 16;
  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE     = 64;

  typedef struct {
    logic              wvalid;
    logic [PIXEL_W-1:0] wmax;
    logic [PIXEL_W-1:0] wmin;
    logic [PIXEL_W-1:0] best;
    logic              done;
  } window_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = CFG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [PIXEL_W-1:0]    pixel_i = '0;
  logic                  start_of_frame_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  window_valid_o;
  logic [PIXEL_W-1:0]    window_max_o;
  logic [PIXEL_W-1:0]    window_min_o;
  logic [PIXEL_W-1:0]    best_range_o;
  logic                  frame_done_o;

  window_range_min_finder uut (.*);

  always begin
    #6 clk_i = 1'b0;
    #6 clk_i = 1'b1;
  end

  // golden model state
  logic [FW_W-1:0]    m_width = 11'd1024;
  logic [FH_W-1:0]    m_height = 13'd1024;
  logic [WS_W-1:0]    m_window = 5'd2;
  logic [PIXEL_W-1:0] m_row_px [WIN_MAX];
  logic [PIXEL_W-1:0] m_line_max [WIN_MAX*LINE_W];
  logic [PIXEL_W-1:0] m_line_min [WIN_MAX*LINE_W];
  int                 m_col = 0;
  int                 m_row = 0;
  logic [PIXEL_W-1:0] m_best = '1;

  window_result_t pending_windows[$];
  int errors = 0;
  int burst_left = 0;
  int hold_request = 0;
  int hold_served = 0;
  int hold_left = 0;
  int stall_mode = 0;
  int idle_cycles = 0;

  initial begin
    for (int i = 0; i < WIN_MAX; i++) m_row_px[i] = '0;
  end

  function automatic int clamp_reg(int v, int hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic void predict_window(logic [PIXEL_W-1:0] px, logic sof);
    int w, h, ws, col, row, base, idx;
    logic [PIXEL_W-1:0] hmax, hmin, vmax, vmin;
    logic last_col;
    window_result_t r;
    w = clamp_reg(int'(m_width), LINE_W);
    h = clamp_reg(int'(m_height), MAX_HEIGHT);
    ws = clamp_reg(int'(m_window), WIN_MAX);
    if (sof) begin
      m_col = 0;
      m_row = 0;
      m_best = '1;
    end
    col = m_col % LINE_W;
    row = m_row % MAX_HEIGHT;
    m_row_px[col % ws] = px;
    hmax = px;
    hmin = px;
    if (col + 1 >= ws) begin
      for (int k = 0; k < ws; k++) begin
        if (m_row_px[k] > hmax) hmax = m_row_px[k];
        if (m_row_px[k] < hmin) hmin = m_row_px[k];
      end
    end
    base = (row % ws) * LINE_W + col;
    m_line_max[base] = hmax;
    m_line_min[base] = hmin;
    vmax = '0;
    vmin = '0;
    r.wvalid = (col + 1 >= ws) && (row + 1 >= ws);
    if (r.wvalid) begin
      vmax = hmax;
      vmin = hmin;
      for (int k = 0; k < ws; k++) begin
        idx = k * LINE_W + col;
        if (m_line_max[idx] > vmax) vmax = m_line_max[idx];
        if (m_line_min[idx] < vmin) vmin = m_line_min[idx];
      end
      if (vmax - vmin < m_best) m_best = vmax - vmin;
    end
    last_col = (col + 1 >= w);
    r.done = last_col && (row + 1 >= h);
    r.wmax = vmax;
    r.wmin = vmin;
    r.best = m_best;
    pending_windows.push_back(r);
    if (last_col) begin
      m_col = 0;
      m_row = r.done ? 0 : row + 1;
    end else begin
      m_col = col + 1;
      m_row = row;
    end
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch on %s: got %0d expected %0d at %0t", field, got, want, $realtime);
    errors++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    window_result_t r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_windows.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
      end else begin
        r = pending_windows.pop_front();
        if (window_valid_o !== r.wvalid) report_mismatch("window_valid", window_valid_o, r.wvalid);
        if (window_max_o !== r.wmax) report_mismatch("window_max", window_max_o, r.wmax);
        if (window_min_o !== r.wmin) report_mismatch("window_min", window_min_o, r.wmin);
        if (best_range_o !== r.best) report_mismatch("best_range", best_range_o, r.best);
        if (frame_done_o !== r.done) report_mismatch("frame_done", frame_done_o, r.done);
      end
    end
  end

  // receiver stall pattern
  always @(negedge clk_i) begin
    if (hold_request != hold_served) begin
      hold_served = hold_request;
      hold_left = 300;
    end
    if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 9) < 3);
        default: out_stall_i <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else if (rst_ni) begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("window_range_min_finder_test failed");
        $finish;
      end
    end
  end

  task automatic send_pixel(logic [PIXEL_W-1:0] px, logic sof);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    pixel_i <= px;
    start_of_frame_i <= sof;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_window(px, sof);
    burst_left--;
  endtask

  task automatic drain;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_windows.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_FRAME_WIDTH: m_width = data[FW_W-1:0];
      CFG_FRAME_HEIGHT: m_height = data[FH_W-1:0];
      CFG_WINDOW_SIZE: m_window = data[WS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic setup_frame(int w, int h, int ws);
    drain();
    write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(w));
    write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(h));
    write_reg(CFG_WINDOW_SIZE, CFG_DATA_W'(ws));
  endtask

  task automatic send_frame(int count, int spread);
    logic [PIXEL_W-1:0] base;
    base = PIXEL_W'($urandom);
    for (int i = 0; i < count; i++) begin
      if (spread == 0) send_pixel(PIXEL_W'($urandom), i == 0);
      else send_pixel(base + PIXEL_W'($urandom_range(0, spread)), i == 0);
    end
  endtask

  task automatic test_defaults;
    send_pixel(16'hffff, 1'b1);
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'h8000, 1'b0);
    send_pixel(16'h7fff, 1'b0);
  endtask

  task automatic test_small_frame;
    setup_frame(3, 3, 2);
    send_pixel(16'h0000, 1'b1);
    send_pixel(16'hffff, 1'b0);
    send_pixel(16'h0010, 1'b0);
    send_pixel(16'h0011, 1'b0);
    send_pixel(16'h0012, 1'b0);
    send_pixel(16'h0013, 1'b0);
    send_pixel(16'hffff, 1'b0);
    send_pixel(16'h0014, 1'b0);
    send_pixel(16'h0015, 1'b0);
    // next frame without start flag keeps the best range
    for (int i = 0; i < 9; i++) send_pixel(PIXEL_W'(32'hf000 + 32'h0100 * i), 1'b0);
  endtask

  task automatic test_window_too_big;
    setup_frame(2, 2, 31);
    for (int i = 0; i < 4; i++) send_pixel(PIXEL_W'(32'h1234 * i), i == 0);
  endtask

  task automatic test_zero_regs;
    setup_frame(0, 0, 0);
    send_pixel(16'h5555, 1'b1);
    send_pixel(16'haaaa, 1'b0);
    send_pixel(16'h0001, 1'b0);
  endtask

  task automatic test_largest_regs;
    setup_frame(13'h1fff, 13'h1fff, 16);
    send_frame(20, 0);
    setup_frame(16, 16, 16);
    send_frame(16 * 16, 200);
  endtask

  task automatic test_backpressure;
    setup_frame(6, 5, 3);
    hold_request++;
    send_frame(60, 1000);
  endtask

  task automatic test_random_frames;
    int w, h, ws, n;
    for (int p = 0; p < 3; p++) begin
      w = $urandom_range(1, 10);
      h = $urandom_range(1, 8);
      ws = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 4);
      setup_frame(w, h, ws);
      n = w * h + $urandom_range(0, 3);
      for (int i = 0; i < n; i++) begin
        if (i == 0) send_pixel(PIXEL_W'($urandom), 1'b1);
        else if ($urandom_range(0, 49) == 0) send_pixel(PIXEL_W'($urandom), 1'b1);
        else if (p % 2 == 0) send_pixel(PIXEL_W'($urandom_range(1000, 1300)), 1'b0);
        else send_pixel(PIXEL_W'($urandom), 1'b0);
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_defaults();
    test_small_frame();
    test_window_too_big();
    test_zero_regs();
    test_largest_regs();
    test_backpressure();
    test_random_frames();
    drain();
    if (errors == 0) begin
      $display("window_range_min_finder_test passed");
    end else begin
      $display("window_range_min_finder_test failed");
    end
    $finish;
  end

endmodule
